/* rtl/qrs_pkg.sv */
package qrs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CW = 32;            // coefficient / root width
  localparam int DW = 66;            // discriminant width
  localparam int SW = DW / 2;        // square root width
  localparam int RW = SW + 3;        // square root remainder width
  localparam int TW = SW + 1;        // |b| + s width, also divisor width
  localparam int NW = 2 * CW;        // dividend width
  localparam int SQ_CELLS = SW;
  localparam int DV_CELLS = CW;

  typedef enum logic [1:0] {
    ST_TWO    = 2'd0,
    ST_NODISC = 2'd1,
    ST_AZERO  = 2'd2
  } status_t;

  typedef struct packed {
    status_t         status;
    logic            na;
    logic            nb;
    logic            nc;
    logic [CW-1:0]   ma;
    logic [CW-1:0]   mb;
    logic [CW-1:0]   mc;
  } sq_tag_t;

  typedef struct packed {
    logic [RW-1:0] rem;
    logic [SW-1:0] root;
    logic [DW-1:0] d;
    sq_tag_t       tag;
  } sq_t;

  typedef struct packed {
    logic [TW-1:0] dv;
    logic [TW-1:0] rem;
    logic [CW-1:0] num;
    logic [CW-1:0] q;
    logic          ovf;
    logic          neg;
  } lane_t;

  typedef struct packed {
    lane_t [1:0] lane;
    status_t     status;
  } dv_t;

endpackage

/* rtl/qrs_if.sv */
interface qrs_coeff_if;
  logic                         valid;
  logic                         ready;
  logic signed [qrs_pkg::CW-1:0] coeff_a;
  logic signed [qrs_pkg::CW-1:0] coeff_b;
  logic signed [qrs_pkg::CW-1:0] coeff_c;
  modport source(output valid, coeff_a, coeff_b, coeff_c, input ready);
  modport sink(input valid, coeff_a, coeff_b, coeff_c, output ready);
endinterface

interface qrs_root_if;
  logic                         valid;
  logic                         ready;
  logic signed [qrs_pkg::CW-1:0] root_near;
  logic signed [qrs_pkg::CW-1:0] root_far;
  logic [1:0]                   status;
  logic                         saturated;
  modport source(output valid, root_near, root_far, status, saturated, input ready);
  modport sink(input valid, root_near, root_far, status, saturated, output ready);
endinterface

/* rtl/qrs_sqrt_cell.sv */
// One root bit per cell: consumes two discriminant bits.
module qrs_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  qrs_pkg::sq_t  din,
  output logic          vout,
  output qrs_pkg::sq_t  dout
);
  logic [qrs_pkg::RW-1:0] cur;
  logic [qrs_pkg::RW-1:0] trial;
  qrs_pkg::sq_t           nxt;

  always_comb begin
    cur   = {din.rem[qrs_pkg::RW-3:0], din.d[qrs_pkg::DW-1 -: 2]};
    trial = {{(qrs_pkg::RW-qrs_pkg::SW-2){1'b0}}, din.root, 2'b01};
    nxt   = din;
    nxt.d = {din.d[qrs_pkg::DW-3:0], 2'b00};
    if (cur >= trial) begin
      nxt.rem  = cur - trial;
      nxt.root = {din.root[qrs_pkg::SW-2:0], 1'b1};
    end else begin
      nxt.rem  = cur;
      nxt.root = {din.root[qrs_pkg::SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

/* rtl/qrs_div_cell.sv */
// One quotient bit per cell, for both root lanes side by side.
module qrs_div_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          vin,
  input  qrs_pkg::dv_t  din,
  output logic          vout,
  output qrs_pkg::dv_t  dout
);
  logic [qrs_pkg::TW:0] cur [2];
  qrs_pkg::dv_t         nxt;

  always_comb begin
    nxt = din;
    for (int i = 0; i < 2; i++) begin
      cur[i] = {din.lane[i].rem, din.lane[i].num[qrs_pkg::CW-1]};
      nxt.lane[i].num = {din.lane[i].num[qrs_pkg::CW-2:0], 1'b0};
      if (cur[i] >= {1'b0, din.lane[i].dv}) begin
        nxt.lane[i].rem = qrs_pkg::TW'(cur[i] - {1'b0, din.lane[i].dv});
        nxt.lane[i].q   = {din.lane[i].q[qrs_pkg::CW-2:0], 1'b1};
      end else begin
        nxt.lane[i].rem = cur[i][qrs_pkg::TW-1:0];
        nxt.lane[i].q   = {din.lane[i].q[qrs_pkg::CW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end
endmodule

/* rtl/quadratic_root_solver.sv */
// channel  | dir | payload                                  | handshake
// coeffs   | in  | coeff_a, coeff_b, coeff_c (Q.FRAC_BITS)  | valid/ready
// roots    | out | root_near, root_far, status, saturated    | valid/ready
//
// One item per cycle sustained while roots does not stall.
// The pipe holds the 33-cell square root chain and the 32-cell divider chain.
// Synchronous active-high reset clears all valid bits; payload is not reset.
// A stall on roots freezes the whole pipe; the entry register still takes an
// item while it is empty.
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input logic             clk,
  input logic             rst,
  qrs_coeff_if.sink       coeffs,
  qrs_root_if.source      roots
);
  localparam int CW = qrs_pkg::CW;

  logic en;
  logic load1;

  // entry stage: magnitudes and signs
  logic          v1;
  logic          na1, nb1, nc1;
  logic [CW-1:0] ma1, mb1, mc1;

  // multiply stage
  logic            v2;
  logic            na2, nb2, nc2;
  logic [CW-1:0]   ma2, mb2, mc2;
  logic [2*CW-1:0] b2, p2;

  // discriminant stage, head of the root chain
  logic                  v3;
  qrs_pkg::sq_t          sq3;
  logic signed [qrs_pkg::DW:0] dsum;
  qrs_pkg::status_t      st3;

  assign en     = !roots.valid || roots.ready;
  assign load1  = en || !v1;
  assign coeffs.ready = load1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (load1) v1 <= coeffs.valid;
      if (en) begin
        v2 <= v1;
        v3 <= v2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      na1 <= coeffs.coeff_a[CW-1];
      nb1 <= coeffs.coeff_b[CW-1];
      nc1 <= coeffs.coeff_c[CW-1];
      ma1 <= coeffs.coeff_a[CW-1] ? CW'(-coeffs.coeff_a) : coeffs.coeff_a;
      mb1 <= coeffs.coeff_b[CW-1] ? CW'(-coeffs.coeff_b) : coeffs.coeff_b;
      mc1 <= coeffs.coeff_c[CW-1] ? CW'(-coeffs.coeff_c) : coeffs.coeff_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {na2, nb2, nc2} <= {na1, nb1, nc1};
      {ma2, mb2, mc2} <= {ma1, mb1, mc1};
      b2 <= {{CW{1'b0}}, mb1} * {{CW{1'b0}}, mb1};
      p2 <= {{CW{1'b0}}, ma1} * {{CW{1'b0}}, mc1};
    end
  end

  // d = b^2 - 4ac; a*c negative only when c is nonzero and signs differ
  always_comb begin
    if ((na2 != nc2) && (mc2 != '0)) begin
      dsum = $signed({3'b000, b2}) + $signed({1'b0, p2, 2'b00});
    end else begin
      dsum = $signed({3'b000, b2}) - $signed({1'b0, p2, 2'b00});
    end
    if (ma2 == '0) begin
      st3 = qrs_pkg::ST_AZERO;
    end else if (dsum[qrs_pkg::DW] || (dsum == '0)) begin
      st3 = qrs_pkg::ST_NODISC;
    end else begin
      st3 = qrs_pkg::ST_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq3.rem        <= '0;
      sq3.root       <= '0;
      sq3.d          <= dsum[qrs_pkg::DW-1:0];
      sq3.tag.status <= st3;
      sq3.tag.na     <= na2;
      sq3.tag.nb     <= nb2;
      sq3.tag.nc     <= nc2;
      sq3.tag.ma     <= ma2;
      sq3.tag.mb     <= mb2;
      sq3.tag.mc     <= mc2;
    end
  end

  // floor(sqrt(d)), one bit per cell
  logic         sqv [qrs_pkg::SQ_CELLS+1];
  qrs_pkg::sq_t sqd [qrs_pkg::SQ_CELLS+1];
  assign sqv[0] = v3;
  assign sqd[0] = sq3;

  for (genvar g = 0; g < qrs_pkg::SQ_CELLS; g++) begin : g_sq
    qrs_sqrt_cell u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (sqv[g]), .din (sqd[g]),
      .vout(sqv[g+1]), .dout(sqd[g+1])
    );
  end

  // divider set-up: q/a = t*2^(F-1)/|a|, c/q = |c|*2^(F+1)/t, t = |b| + s
  qrs_pkg::sq_t         sqo;
  logic [qrs_pkg::TW-1:0] tsum;
  logic [qrs_pkg::NW-1:0] n0, n1;
  logic [qrs_pkg::TW-1:0] dv0;
  logic                 ov0, ov1;
  logic                 v4;
  qrs_pkg::dv_t         dv4;

  always_comb begin
    sqo  = sqd[qrs_pkg::SQ_CELLS];
    tsum = qrs_pkg::TW'(sqo.tag.mb) + qrs_pkg::TW'(sqo.root);
    n0   = qrs_pkg::NW'(tsum) << (FRAC_BITS - 1);
    n1   = qrs_pkg::NW'(sqo.tag.mc) << (FRAC_BITS + 1);
    dv0  = qrs_pkg::TW'(sqo.tag.ma);
    ov0  = qrs_pkg::TW'(n0[qrs_pkg::NW-1:CW]) >= dv0;
    ov1  = qrs_pkg::TW'(n1[qrs_pkg::NW-1:CW]) >= tsum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= sqv[qrs_pkg::SQ_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv4.status      <= sqo.tag.status;
      dv4.lane[0].dv  <= dv0;
      dv4.lane[0].rem <= ov0 ? '0 : qrs_pkg::TW'(n0[qrs_pkg::NW-1:CW]);
      dv4.lane[0].num <= n0[CW-1:0];
      dv4.lane[0].q   <= '0;
      dv4.lane[0].ovf <= ov0;
      dv4.lane[0].neg <= sqo.tag.nb == sqo.tag.na;
      dv4.lane[1].dv  <= tsum;
      dv4.lane[1].rem <= ov1 ? '0 : qrs_pkg::TW'(n1[qrs_pkg::NW-1:CW]);
      dv4.lane[1].num <= n1[CW-1:0];
      dv4.lane[1].q   <= '0;
      dv4.lane[1].ovf <= ov1;
      dv4.lane[1].neg <= sqo.tag.nb == sqo.tag.nc;
    end
  end

  // both divisions, one quotient bit per cell
  logic         dvv [qrs_pkg::DV_CELLS+1];
  qrs_pkg::dv_t dvd [qrs_pkg::DV_CELLS+1];
  assign dvv[0] = v4;
  assign dvd[0] = dv4;

  for (genvar g = 0; g < qrs_pkg::DV_CELLS; g++) begin : g_dv
    qrs_div_cell u_cell (
      .clk (clk), .rst (rst), .en (en),
      .vin (dvv[g]), .din (dvd[g]),
      .vout(dvv[g+1]), .dout(dvd[g+1])
    );
  end

  // clamp, sign, order
  qrs_pkg::dv_t         dvo;
  logic signed [CW-1:0] r [2];
  logic                 sat [2];
  logic signed [CW-1:0] lo, hi;

  always_comb begin
    dvo = dvd[qrs_pkg::DV_CELLS];
    for (int i = 0; i < 2; i++) begin
      sat[i] = 1'b0;
      if (dvo.lane[i].neg) begin
        if (dvo.lane[i].ovf || (dvo.lane[i].q > {1'b1, {(CW-1){1'b0}}})) begin
          r[i]   = {1'b1, {(CW-1){1'b0}}};
          sat[i] = 1'b1;
        end else begin
          r[i] = CW'(-dvo.lane[i].q);
        end
      end else begin
        if (dvo.lane[i].ovf || dvo.lane[i].q[CW-1]) begin
          r[i]   = {1'b0, {(CW-1){1'b1}}};
          sat[i] = 1'b1;
        end else begin
          r[i] = dvo.lane[i].q;
        end
      end
    end
    if (r[0] > r[1]) begin
      lo = r[1];
      hi = r[0];
    end else begin
      lo = r[0];
      hi = r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      roots.valid <= 1'b0;
    end else if (en) begin
      roots.valid <= dvv[qrs_pkg::DV_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roots.status <= dvo.status;
      if (dvo.status == qrs_pkg::ST_TWO) begin
        roots.root_near <= lo;
        roots.root_far  <= hi;
        roots.saturated <= sat[0] || sat[1];
      end else begin
        roots.root_near <= '0;
        roots.root_far  <= '0;
        roots.saturated <= 1'b0;
      end
    end
  end

  a_reset_clears: assert property (@(posedge clk) rst |=> !roots.valid)
    else $error("output valid after reset");
  a_stall_entry: assert property (@(posedge clk) disable iff (rst)
    (coeffs.valid && coeffs.ready && !en) |-> !v1)
    else $error("entry overwritten during stall");
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (roots.valid && (roots.status != qrs_pkg::ST_TWO)) |->
    (roots.root_near == '0 && roots.root_far == '0 && !roots.saturated))
    else $error("fault item carries roots");
  a_ordered: assert property (@(posedge clk) disable iff (rst)
    (roots.valid && (roots.status == qrs_pkg::ST_TWO)) |->
    (roots.root_near <= roots.root_far))
    else $error("roots out of order");
endmodule
